// ===== design/fcgi_pkg.sv =====
`timescale 1ns / 1ps

package fcgi_pkg;

  localparam int unsigned CfgIdxW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgExpectedVersion = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxRecordType   = 8'd1;

  localparam logic [7:0] CfgVersionReset = 8'd1;
  localparam logic [7:0] CfgMaxTypeReset = 8'd11;

  // record types of interest
  localparam logic [7:0] TypeEndRequest = 8'd3;
  localparam logic [7:0] TypeStdout     = 8'd6;
  localparam logic [7:0] TypeStderr     = 8'd7;

  localparam logic [15:0] EndBodyLen = 16'd8;

  // sticky error codes
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrVersion   = 3'd1;
  localparam logic [2:0] ErrType      = 3'd2;
  localparam logic [2:0] ErrEndLength = 3'd3;
  localparam logic [2:0] ErrEndStatus = 3'd4;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        stream_kind;
    logic [7:0]  record_type;
    logic        record_done;
    logic [2:0]  error_code;
    logic        exit_valid;
    logic [31:0] exit_status;
  } res_t;

endpackage

// ===== design/fcgi_parser.sv =====
`timescale 1ns / 1ps

module fcgi_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic [7:0]         exp_version_i,
  input  logic [7:0]         max_type_i,
  output fcgi_pkg::res_t     res_o
);
  import fcgi_pkg::*;

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhContent = 2'd1;
  localparam logic [1:0] PhPadding = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  cur_type_q, cur_type_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] content_left_q, content_left_d;
  logic [7:0]  pad_left_q, pad_left_d;
  logic [31:0] app_acc_q, app_acc_d;
  logic [7:0]  proto_q, proto_d;
  logic [2:0]  err_q, err_d;
  logic [15:0] pos;
  logic        ov, sk, done, ev;
  logic [7:0]  ob;
  logic [31:0] es;

  always_comb begin
    phase_d        = phase_q;
    hdr_idx_d      = hdr_idx_q;
    cur_type_d     = cur_type_q;
    len_hi_d       = len_hi_q;
    content_left_d = content_left_q;
    pad_left_d     = pad_left_q;
    app_acc_d      = app_acc_q;
    proto_d        = proto_q;
    err_d          = err_q;
    pos            = EndBodyLen - content_left_q;
    ov             = 1'b0;
    ob             = 8'd0;
    sk             = 1'b0;
    done           = 1'b0;
    ev             = 1'b0;
    es             = 32'd0;

    if (err_q == ErrNone) begin
      if (phase_q == PhContent) begin
        content_left_d = content_left_q - 16'd1;
        if (cur_type_q == TypeStdout || cur_type_q == TypeStderr) begin
          ov = 1'b1;
          ob = byte_i;
          sk = (cur_type_q == TypeStderr);
        end else if (cur_type_q == TypeEndRequest) begin
          if (pos < 16'd4) begin
            app_acc_d = {app_acc_q[23:0], byte_i};
          end else if (pos == 16'd4) begin
            proto_d = byte_i;
          end
          if (content_left_d == 16'd0) begin
            if (proto_d != 8'd0) begin
              err_d = ErrEndStatus;
            end else begin
              ev = 1'b1;
              es = app_acc_d;
            end
          end
        end
        if (err_d == ErrNone && content_left_d == 16'd0) begin
          if (pad_left_q != 8'd0) begin
            phase_d = PhPadding;
          end else begin
            phase_d = PhHeader;
            done    = 1'b1;
          end
        end
      end else if (phase_q == PhPadding) begin
        pad_left_d = pad_left_q - 8'd1;
        if (pad_left_d == 8'd0) begin
          phase_d = PhHeader;
          done    = 1'b1;
        end
      end else begin
        // header phase (the unused phase code behaves the same)
        case (hdr_idx_q)
          3'd0: begin
            cur_type_d = 8'd0;
            if (byte_i != exp_version_i) err_d = ErrVersion;
          end
          3'd1: begin
            cur_type_d = byte_i;
            if (byte_i > max_type_i) err_d = ErrType;
          end
          3'd4: len_hi_d = byte_i;
          3'd5: content_left_d = {len_hi_q, byte_i};
          3'd6: pad_left_d = byte_i;
          3'd7: begin
            app_acc_d = 32'd0;
            proto_d   = 8'd0;
            if (cur_type_q == TypeEndRequest && content_left_q != EndBodyLen) begin
              err_d = ErrEndLength;
            end else if (content_left_q != 16'd0) begin
              phase_d = PhContent;
            end else if (pad_left_q != 8'd0) begin
              phase_d = PhPadding;
            end else begin
              phase_d = PhHeader;
              done    = 1'b1;
            end
          end
          default: ;
        endcase
        hdr_idx_d = hdr_idx_q + 3'd1;
        if (err_d != ErrNone) done = 1'b0;
      end
    end

    res_o.out_valid   = ov;
    res_o.out_byte    = ob;
    res_o.stream_kind = sk;
    res_o.record_type = cur_type_d;
    res_o.record_done = done;
    res_o.error_code  = err_d;
    res_o.exit_valid  = ev;
    res_o.exit_status = es;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHeader;
      hdr_idx_q      <= 3'd0;
      cur_type_q     <= 8'd0;
      len_hi_q       <= 8'd0;
      content_left_q <= 16'd0;
      pad_left_q     <= 8'd0;
      app_acc_q      <= 32'd0;
      proto_q        <= 8'd0;
      err_q          <= ErrNone;
    end else if (step_i) begin
      phase_q        <= phase_d;
      hdr_idx_q      <= hdr_idx_d;
      cur_type_q     <= cur_type_d;
      len_hi_q       <= len_hi_d;
      content_left_q <= content_left_d;
      pad_left_q     <= pad_left_d;
      app_acc_q      <= app_acc_d;
      proto_q        <= proto_d;
      err_q          <= err_d;
    end
  end

endmodule

// ===== design/fastcgi_record_deframer_top.sv =====
// FastCGI record deframer.
// Input channel: one raw stream byte per transfer on in_valid_i/in_ready_o.
// Result channel: exactly one result per input byte on res_valid_o/res_ready_i,
// carrying the forwarded content byte (out_valid_o qualifies it), the record
// type, end-of-record and end-request exit status flags and the sticky error.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 expected version, 1 max record type); other indexes are ignored.
// Write only while the block is idle.
// Path: the byte sits in the input register after its transfer; the parser
// step then runs it into the result register and raises res_valid_o, once
// the result register is empty or its result is being taken.
// Throughput: one byte per cycle while the receiver keeps taking results;
// the parser state is a handful of counters updated on each byte, so bytes
// may follow back to back.
// Reset clears the parser to the header phase with no error, empties both
// registers and restores the configuration defaults (version 1, max type 11).
// When the receiver stalls, the result register holds and the input register
// takes one more byte; after that in_ready_o drops until the result moves.
`timescale 1ns / 1ps

module fastcgi_record_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_byte_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic                        out_valid_o,
  output logic [7:0]                  out_byte_o,
  output logic                        stream_kind_o,
  output logic [7:0]                  record_type_o,
  output logic                        record_done_o,
  output logic [2:0]                  error_code_o,
  output logic                        exit_valid_o,
  output logic [31:0]                 exit_status_o,
  input  logic                        cfg_we_i,
  input  logic [fcgi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_wdata_i
);
  import fcgi_pkg::*;

  logic       in_full_q;
  logic [7:0] in_byte_q;
  logic       res_vld_q;
  res_t       res_q;
  res_t       res_d;
  logic       adv;
  logic [7:0] exp_version_q;
  logic [7:0] max_type_q;

  assign adv        = in_full_q && (!res_vld_q || res_ready_i);
  assign in_ready_o = !in_full_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= CfgVersionReset;
      max_type_q    <= CfgMaxTypeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgExpectedVersion: exp_version_q <= cfg_wdata_i;
        CfgMaxRecordType:   max_type_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_ready_o) begin
      in_full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_byte_q <= in_byte_i;
  end

  fcgi_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .byte_i        (in_byte_q),
    .exp_version_i (exp_version_q),
    .max_type_i    (max_type_q),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign res_valid_o   = res_vld_q;
  assign out_valid_o   = res_q.out_valid;
  assign out_byte_o    = res_q.out_byte;
  assign stream_kind_o = res_q.stream_kind;
  assign record_type_o = res_q.record_type;
  assign record_done_o = res_q.record_done;
  assign error_code_o  = res_q.error_code;
  assign exit_valid_o  = res_q.exit_valid;
  assign exit_status_o = res_q.exit_status;

  // an error, once reported, stays in every later result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_vld_q && res_q.error_code != ErrNone)
      |=> (res_q.error_code == $past(res_q.error_code)))
    else $error("sticky error code changed");

  // forwarded content never comes with an error or an exit report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && out_valid_o) |-> (error_code_o == ErrNone && !exit_valid_o))
    else $error("forwarded byte with error or exit");

  // exit status only comes from an end-request record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && exit_valid_o) |-> (record_type_o == TypeEndRequest))
    else $error("exit report outside end-request record");

  // input stalls only when both registers are held by a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_full_q && res_vld_q && !res_ready_i))
    else $error("input stalled without output backpressure");

endmodule
